FILE: rtl/core/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// Types and polynomial constants shared by the fixed-point sine/cosine core.
// ----------------------------------------------------------------------------
package fpsc_pkg;

    localparam int ANGLE_W  = 16;
    localparam int R_W      = 14;   // folded offset, 0..0x2000
    localparam int R2_W     = 27;   // offset squared, 0..0x4000000
    localparam int MAG_W    = 17;   // Q16 magnitude, 0..0x10000
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    localparam logic [R_W-1:0] HALF_OCTANT = 14'h2000;

    // cosine coefficients
    localparam logic [22:0] COS_A = 23'h5397b5;
    localparam logic [38:0] COS_B = 39'h40ebd73ac5;
    localparam logic [36:0] COS_C = 37'h13bd391496;
    localparam logic [31:0] COS_D = 32'hffffff8a;

    // sine coefficients
    localparam logic [22:0] SIN_A = 23'h4f880b;
    localparam logic [37:0] SIN_B = 38'h295358621e;
    localparam logic [34:0] SIN_C = 35'h6487cc5bd;

    // per-stage control: octant holds angle bits 15..13
    typedef struct packed {
        logic       valid;
        logic [2:0] octant;
    } fpsc_ctrl_t;

    // result item, cos_negative in the lowest bit
    typedef struct packed {
        logic [MAG_W-1:0] sin_magnitude;
        logic             sin_negative;
        logic [MAG_W-1:0] cos_magnitude;
        logic             cos_negative;
    } fpsc_result_t;

endpackage

FILE: rtl/core/fpsc_fold.sv
// ----------------------------------------------------------------------------
// fpsc_fold
// Input stage: folds the angle into an offset of at most 1/8 turn.
// ----------------------------------------------------------------------------
module fpsc_fold (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [fpsc_pkg::ANGLE_W-1:0]  angle,
    output fpsc_pkg::fpsc_ctrl_t          ctrl,
    output logic [fpsc_pkg::R_W-1:0]      r
);

    fpsc_pkg::fpsc_ctrl_t         ctrl_reg;
    fpsc_pkg::fpsc_ctrl_t         ctrl_next;
    logic [fpsc_pkg::R_W-1:0]     r_reg;
    logic [fpsc_pkg::R_W-1:0]     r_next;
    logic [fpsc_pkg::R_W-1:0]     low;

    assign low = {1'b0, angle[12:0]};

    always_comb begin
        ctrl_next.valid  = in_valid;
        ctrl_next.octant = angle[15:13];
        // upper half of a quadrant (odd octant) measures back from the next quarter turn
        r_next = angle[13] ? (fpsc_pkg::HALF_OCTANT - low) : low;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    assign ctrl = ctrl_reg;
    assign r    = r_reg;

endmodule

FILE: rtl/core/fpsc_poly.sv
// ----------------------------------------------------------------------------
// fpsc_poly
// Five-stage pipeline evaluating the cosine and sine minimax polynomials.
// ----------------------------------------------------------------------------
module fpsc_poly (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  fpsc_pkg::fpsc_ctrl_t          ctrl_in,
    input  logic [fpsc_pkg::R_W-1:0]      r_in,
    output fpsc_pkg::fpsc_ctrl_t          ctrl_out,
    output logic [fpsc_pkg::MAG_W-1:0]    cos_val,
    output logic [fpsc_pkg::MAG_W-1:0]    sin_val
);

    localparam int RW  = fpsc_pkg::R_W;
    localparam int R2W = fpsc_pkg::R2_W;
    localparam int MW  = fpsc_pkg::MAG_W;

    fpsc_pkg::fpsc_ctrl_t ctrl_1_reg, ctrl_2_reg, ctrl_3_reg, ctrl_4_reg, ctrl_5_reg;

    // stage 1
    logic [RW-1:0]      r_1_reg;
    logic [R2W-1:0]     r2_1_reg;
    logic [2*RW-1:0]    sq_full;
    // stage 2
    logic [RW-1:0]      r_2_reg;
    logic [R2W-1:0]     r2_2_reg;
    logic [49:0]        mc_2_reg, ms_2_reg;
    // stage 3
    logic [RW-1:0]      r_3_reg;
    logic [R2W-1:0]     r2_3_reg;
    logic [31:0]        mc_3_reg, ms_3_reg;
    logic [38:0]        pc_3;
    logic [37:0]        ps_3;
    logic [65:0]        prod_c3;
    logic [64:0]        prod_s3;
    // stage 4
    logic [31:0]        mc_4_reg;
    logic [48:0]        ms_4_reg;
    logic [36:0]        pc_4;
    logic [34:0]        ps_4;
    logic [63:0]        prod_c4;
    logic [48:0]        prod_s4;
    // stage 5
    logic [MW-1:0]      cos_5_reg, sin_5_reg;
    logic [31:0]        pc_5;
    logic [MW-1:0]      cos_5_next, sin_5_next;

    assign sq_full = r_in * r_in;

    assign pc_3    = fpsc_pkg::COS_B - 39'(mc_2_reg[49:16]);
    assign ps_3    = fpsc_pkg::SIN_B - 38'(ms_2_reg[49:16]);
    assign prod_c3 = 66'(pc_3) * 66'(r2_2_reg);
    assign prod_s3 = 65'(ps_3) * 65'(r2_2_reg);

    assign pc_4    = fpsc_pkg::COS_C - 37'(mc_3_reg);
    assign ps_4    = fpsc_pkg::SIN_C - 35'(ms_3_reg);
    assign prod_c4 = 64'(pc_4) * 64'(r2_3_reg);
    assign prod_s4 = 49'(ps_4) * 49'(r_3_reg);

    // round half up to Q16
    assign pc_5       = fpsc_pkg::COS_D - mc_4_reg;
    assign cos_5_next = {1'b0, pc_5[31:16]} + MW'(pc_5[15]);
    assign sin_5_next = ms_4_reg[48:32] + MW'(ms_4_reg[31]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_1_reg <= '0;
            ctrl_2_reg <= '0;
            ctrl_3_reg <= '0;
            ctrl_4_reg <= '0;
            ctrl_5_reg <= '0;
        end else if (en) begin
            ctrl_1_reg <= ctrl_in;
            ctrl_2_reg <= ctrl_1_reg;
            ctrl_3_reg <= ctrl_2_reg;
            ctrl_4_reg <= ctrl_3_reg;
            ctrl_5_reg <= ctrl_4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_1_reg   <= r_in;
            r2_1_reg  <= sq_full[R2W-1:0];

            r_2_reg   <= r_1_reg;
            r2_2_reg  <= r2_1_reg;
            mc_2_reg  <= 50'(fpsc_pkg::COS_A) * 50'(r2_1_reg);
            ms_2_reg  <= 50'(fpsc_pkg::SIN_A) * 50'(r2_1_reg);

            // keep bits 63..32: the wrap to 64 bits then the shift
            r_3_reg   <= r_2_reg;
            r2_3_reg  <= r2_2_reg;
            mc_3_reg  <= prod_c3[63:32];
            ms_3_reg  <= prod_s3[63:32];

            mc_4_reg  <= prod_c4[63:32];
            ms_4_reg  <= prod_s4;

            cos_5_reg <= cos_5_next;
            sin_5_reg <= sin_5_next;
        end
    end

    assign ctrl_out = ctrl_5_reg;
    assign cos_val  = cos_5_reg;
    assign sin_val  = sin_5_reg;

endmodule

FILE: rtl/core/fpsc_quad.sv
// ----------------------------------------------------------------------------
// fpsc_quad
// Maps the first-octant results to the full turn: swap and sign selection.
// ----------------------------------------------------------------------------
module fpsc_quad (
    input  logic [2:0]                    octant,
    input  logic [fpsc_pkg::MAG_W-1:0]    cos_val,
    input  logic [fpsc_pkg::MAG_W-1:0]    sin_val,
    output fpsc_pkg::fpsc_result_t        result
);

    logic                         swap;
    logic [fpsc_pkg::MAG_W-1:0]   c_mag;
    logic [fpsc_pkg::MAG_W-1:0]   s_mag;

    // octant holds angle bits 15..13
    assign swap  = octant[1] ^ octant[0];
    assign c_mag = swap ? sin_val : cos_val;
    assign s_mag = swap ? cos_val : sin_val;

    always_comb begin
        result.cos_magnitude = c_mag;
        result.sin_magnitude = s_mag;
        result.cos_negative  = (octant[2] ^ octant[1]) && (c_mag != '0);
        result.sin_negative  = octant[2] && (s_mag != '0);
    end

endmodule

FILE: rtl/core/fpsc_skid.sv
// ----------------------------------------------------------------------------
// fpsc_skid
// Output register with a one-entry skid buffer and a registered ready.
// ----------------------------------------------------------------------------
module fpsc_skid (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  fpsc_pkg::fpsc_result_t    in_data,
    output logic                      in_ready,
    output logic                      out_valid,
    output fpsc_pkg::fpsc_result_t    out_data,
    input  logic                      out_ready
);

    logic                     ready_reg, ready_next;
    logic                     out_valid_reg, out_valid_next;
    fpsc_pkg::fpsc_result_t   out_data_reg, out_data_next;
    fpsc_pkg::fpsc_result_t   skid_data_reg, skid_data_next;
    logic                     pop;
    logic                     push;

    assign pop  = out_valid_reg && out_ready;
    assign push = in_valid && ready_reg;

    always_comb begin
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        skid_data_next = skid_data_reg;
        if (!ready_reg) begin
            // skid full, output is holding: drain skid on transfer
            if (pop) begin
                out_data_next = skid_data_reg;
                ready_next    = 1'b1;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next = in_data;
                ready_next     = 1'b0;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = ready_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/fixed_point_sine_cosine.sv
// ----------------------------------------------------------------------------
// fixed_point_sine_cosine
// Sine and cosine of a 16-bit angle in turns, Q16 sign-magnitude results.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (lowest bit up)
//  --------+-----------+---------------------------------------------------
//  s_      | in        | angle_fraction[15:0]
//  m_      | out       | cos_negative, cos_magnitude[16:0], sin_negative,
//          |           | sin_magnitude[16:0], 4 zero bits
//
//  one angle per cycle while s_tready is high; the polynomial pipeline has no loops
//  m_tvalid follows the input transfer through the fold stage (loaded at the transfer),
//  the five polynomial stages and the output register
//  aresetn clears all valid bits and the skid buffer
//  on a stall the whole pipeline holds; s_tready is a register from the skid
// ----------------------------------------------------------------------------
module fixed_point_sine_cosine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpsc_pkg::S_DATA_W-1:0]     s_tdata,  // angle_fraction[15:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cos_negative, cos_magnitude[16:0], sin_negative, sin_magnitude[16:0], pad
    output logic [fpsc_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam int RES_W = $bits(fpsc_pkg::fpsc_result_t);

    logic                             en;
    fpsc_pkg::fpsc_ctrl_t             fold_ctrl;
    logic [fpsc_pkg::R_W-1:0]         fold_r;
    fpsc_pkg::fpsc_ctrl_t             poly_ctrl;
    logic [fpsc_pkg::MAG_W-1:0]       poly_cos;
    logic [fpsc_pkg::MAG_W-1:0]       poly_sin;
    fpsc_pkg::fpsc_result_t           quad_result;
    fpsc_pkg::fpsc_result_t           out_result;

    fpsc_fold u_fold (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .angle    (s_tdata),
        .ctrl     (fold_ctrl),
        .r        (fold_r)
    );

    fpsc_poly u_poly (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_in  (fold_ctrl),
        .r_in     (fold_r),
        .ctrl_out (poly_ctrl),
        .cos_val  (poly_cos),
        .sin_val  (poly_sin)
    );

    fpsc_quad u_quad (
        .octant   (poly_ctrl.octant),
        .cos_val  (poly_cos),
        .sin_val  (poly_sin),
        .result   (quad_result)
    );

    fpsc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (poly_ctrl.valid),
        .in_data   (quad_result),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_data  (out_result),
        .out_ready (m_tready)
    );

    assign s_tready = en;
    assign m_tdata  = {(fpsc_pkg::M_DATA_W - RES_W)'(0), out_result};

endmodule

FILE: rtl/core/fpsc_checker.sv
// ----------------------------------------------------------------------------
// fpsc_checker
// Port-level checks for the sine/cosine core, bound to the top level.
// ----------------------------------------------------------------------------
module fpsc_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [fpsc_pkg::M_DATA_W-1:0]     m_tdata
);

    // a held result keeps its value until transferred
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input backpressure only while a result is waiting
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no pending result");

    // reset empties the output side
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

    // magnitudes stay within one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:1] <= 17'h10000) && (m_tdata[35:19] <= 17'h10000))
        else $error("magnitude above one");

    // zero is never marked negative
    a_neg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[17:1] == '0))
                  && !(m_tdata[18] && (m_tdata[35:19] == '0)))
        else $error("negative zero result");

endmodule

bind fixed_point_sine_cosine fpsc_checker u_fpsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/fixed_point_sine_cosine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_sine_cosine_tb
// Streams angles into the sine/cosine core with random gaps and back-pressure.
// A scoreboard predicts each Q16 sign-magnitude result and checks the outputs
// in order, field by field.
// ----------------------------------------------------------------------------

class sincos_scoreboard;

    localparam bit [63:0] K_COS_A = 64'h5397b5;
    localparam bit [63:0] K_COS_B = 64'h40ebd73ac5;
    localparam bit [63:0] K_COS_C = 64'h13bd391496;
    localparam bit [63:0] K_COS_D = 64'hffffff8a;
    localparam bit [63:0] K_SIN_A = 64'h4f880b;
    localparam bit [63:0] K_SIN_B = 64'h295358621e;
    localparam bit [63:0] K_SIN_C = 64'h6487cc5bd;

    fpsc_pkg::fpsc_result_t expected_results[$];
    int unsigned            mismatches;
    int unsigned            angles_seen;
    int unsigned            results_checked;
    bit [7:0]               octants_seen;

    // all arithmetic in 64 bits, wrapping like the hardware polynomials
    function automatic fpsc_pkg::fpsc_result_t predict_sincos(input bit [15:0] angle);
        fpsc_pkg::fpsc_result_t res;
        bit [63:0] r;
        bit [63:0] r2;
        bit [63:0] p;
        bit [63:0] wide;
        bit [31:0] cos_val;
        bit [31:0] sin_val;
        bit [31:0] swap_tmp;
        r = angle[13] ? (64'h2000 - {51'd0, angle[12:0]}) : {51'd0, angle[12:0]};
        r2 = r * r;

        p = K_COS_B - ((K_COS_A * r2) >> 16);
        p = K_COS_C - ((p * r2) >> 32);
        p = K_COS_D - ((p * r2) >> 32);
        wide = (p >> 16) + {63'd0, p[15]};
        cos_val = wide[31:0];

        p = K_SIN_B - ((K_SIN_A * r2) >> 16);
        p = K_SIN_C - ((p * r2) >> 32);
        p = p * r;
        wide = (p >> 32) + {63'd0, p[31]};
        sin_val = wide[31:0];

        // octants 1, 2, 5 and 6 (angle bits 14 and 13 differ) trade the two polynomials
        if (angle[14] ^ angle[13]) begin
            swap_tmp = cos_val;
            cos_val = sin_val;
            sin_val = swap_tmp;
        end

        res.cos_negative  = (angle[15] ^ angle[14]) && (cos_val != 0);
        res.cos_magnitude = cos_val[16:0];
        res.sin_negative  = angle[15] && (sin_val != 0);
        res.sin_magnitude = sin_val[16:0];
        return res;
    endfunction

    function void note_angle(input bit [15:0] angle);
        expected_results.push_back(predict_sincos(angle));
        angles_seen++;
        octants_seen[angle[15:13]] = 1'b1;
    endfunction

    function void check_result(input fpsc_pkg::fpsc_result_t actual);
        fpsc_pkg::fpsc_result_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, got %h", $time, actual);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (actual.cos_negative !== want.cos_negative) begin
            $display("%0t: cos_negative expected %0d actual %0d",
                     $time, want.cos_negative, actual.cos_negative);
            mismatches++;
        end
        if (actual.cos_magnitude !== want.cos_magnitude) begin
            $display("%0t: cos_magnitude expected %h actual %h",
                     $time, want.cos_magnitude, actual.cos_magnitude);
            mismatches++;
        end
        if (actual.sin_negative !== want.sin_negative) begin
            $display("%0t: sin_negative expected %0d actual %0d",
                     $time, want.sin_negative, actual.sin_negative);
            mismatches++;
        end
        if (actual.sin_magnitude !== want.sin_magnitude) begin
            $display("%0t: sin_magnitude expected %h actual %h",
                     $time, want.sin_magnitude, actual.sin_magnitude);
            mismatches++;
        end
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

endclass

module fixed_point_sine_cosine_tb;

    localparam int RANDOM_ANGLES = 1950;
    localparam int QUIET_ANGLES  = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // angle_fraction[15:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    // cos_negative, cos_magnitude[16:0], sin_negative, sin_magnitude[16:0], pad
    logic [39:0] m_tdata;

    bit          idling_on = 1'b1;
    int unsigned cycles    = 0;

    sincos_scoreboard sb = new();

    // quadrant and octant edges, zero results in every sign position
    bit [15:0] corner_angles [22] = '{
        16'h0000, 16'h0001, 16'h1000, 16'h1fff, 16'h2000, 16'h2001,
        16'h3fff, 16'h4000, 16'h4001, 16'h6000, 16'h7fff, 16'h8000,
        16'h8001, 16'ha000, 16'hbfff, 16'hc000, 16'hc001, 16'he000,
        16'hfffe, 16'hffff, 16'h5555, 16'haaaa
    };

    fixed_point_sine_cosine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // transfer monitors
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_angle(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(fpsc_pkg::fpsc_result_t'(m_tdata[35:0]));
    end

    // result side back-pressure in random bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (idling_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_angle(input bit [15:0] angle);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic bit [15:0] pick_angle();
        bit [15:0] base;
        bit [15:0] off;
        case ($urandom_range(0, 3))
            0: begin
                // hug an octant boundary from either side
                base = 16'($urandom_range(0, 7)) << 13;
                off  = 16'($urandom_range(0, 4));
                return $urandom_range(0, 1) ? base + off : base - off;
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_angles[i])
            send_angle(corner_angles[i]);
        for (int i = 0; i < RANDOM_ANGLES; i++) begin
            if (i == RANDOM_ANGLES - QUIET_ANGLES)
                idling_on = 1'b0;
            send_angle(pick_angle());
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d angles sent, %0d results checked, octant mask %b",
                 sb.angles_seen, sb.results_checked, sb.octants_seen);
        $display("corner angles plus random and boundary angles under gaps and stalls");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/fpsc_pkg.sv
rtl/core/fpsc_fold.sv
rtl/core/fpsc_poly.sv
rtl/core/fpsc_quad.sv
rtl/core/fpsc_skid.sv
rtl/core/fixed_point_sine_cosine.sv
rtl/core/fpsc_checker.sv
tb/fixed_point_sine_cosine_tb.sv
